// ===== rtl/lrng_pkg.sv =====
package lrng_pkg;

    // request opcodes
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam int SEED_W = 31;
    localparam int FRAC_W = 25;
    localparam int MULT_W = 15;
    localparam int PROD_W = SEED_W + MULT_W;

    localparam logic [SEED_W-1:0] PM_MODULUS  = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] PM_SEED_MAX = 31'h7FFF_FFFE;
    localparam logic [MULT_W-1:0] PM_MUL_A    = 15'd24112;
    localparam logic [MULT_W-1:0] PM_MUL_B    = 15'd26143;

    localparam int SEED_TABLE_LEN = 101;

    // published start seeds, entry 0 is zero
    localparam logic [SEED_W-1:0] SEED_TABLE [0:SEED_TABLE_LEN-1] = '{
        31'd0,
        31'd1973272912, 31'd281629770,  31'd20006270,   31'd1280689831, 31'd2096730329,
        31'd1933576050, 31'd913566091,  31'd246780520,  31'd1363774876, 31'd604901985,
        31'd1511192140, 31'd1259851944, 31'd824064364,  31'd150493284,  31'd242708531,
        31'd75253171,   31'd1964472944, 31'd1202299975, 31'd233217322,  31'd1911216000,
        31'd726370533,  31'd403498145,  31'd993232223,  31'd1103205531, 31'd762430696,
        31'd1922803170, 31'd1385516923, 31'd76271663,   31'd413682397,  31'd726466604,
        31'd336157058,  31'd1432650381, 31'd1120463904, 31'd595778810,  31'd877722890,
        31'd1046574445, 31'd68911991,   31'd2088367019, 31'd748545416,  31'd622401386,
        31'd2122378830, 31'd640690903,  31'd1774806513, 31'd2132545692, 31'd2079249579,
        31'd78130110,   31'd852776735,  31'd1187867272, 31'd1351423507, 31'd1645973084,
        31'd1997049139, 31'd922510944,  31'd2045512870, 31'd898585771,  31'd243649545,
        31'd1004818771, 31'd773686062,  31'd403188473,  31'd372279877,  31'd1901633463,
        31'd498067494,  31'd2087759558, 31'd493157915,  31'd597104727,  31'd1530940798,
        31'd1814496276, 31'd536444882,  31'd1663153658, 31'd855503735,  31'd67784357,
        31'd1432404475, 31'd619691088,  31'd119025595,  31'd880802310,  31'd176192644,
        31'd1116780070, 31'd277854671,  31'd1366580350, 31'd1142483975, 31'd2026948561,
        31'd1053920743, 31'd786262391,  31'd1792203830, 31'd1494667770, 31'd1923011392,
        31'd1433700034, 31'd1244184613, 31'd1147297105, 31'd539712780,  31'd1545929719,
        31'd190641742,  31'd1645390429, 31'd264907697,  31'd620389253,  31'd1502074852,
        31'd927711160,  31'd364849192,  31'd2049576050, 31'd638580085,  31'd547070247
    };

    // fold a product below 2^46 modulo 2^31-1: high part plus low part, one subtract
    function automatic logic [SEED_W-1:0] mod_fold(input logic [PROD_W-1:0] p);
        logic [SEED_W:0] s;
        logic [SEED_W:0] d;
        s = {1'b0, p[SEED_W-1:0]} + (SEED_W+1)'(p[PROD_W-1:SEED_W]);
        d = s - {1'b0, PM_MODULUS};
        return (s >= {1'b0, PM_MODULUS}) ? d[SEED_W-1:0] : s[SEED_W-1:0];
    endfunction

endpackage

// ===== rtl/lrng_mulmod.sv =====
module lrng_mulmod
(
    input  logic        clk,
    input  logic        load,
    input  logic        use_b,
    input  logic [30:0] operand,
    output logic [30:0] reduced
);
    import lrng_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [MULT_W-1:0] mult;

    // constant multiplier select, 31 x 15 product
    assign mult      = use_b ? PM_MUL_B : PM_MUL_A;
    assign prod_next = PROD_W'(operand) * PROD_W'(mult);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign reduced = mod_fold(prod_reg);

endmodule

// ===== rtl/multi_stream_lehmer_rng.sv =====
// a draw steps through ST_READ, ST_REDA, ST_MULB and ST_FIN, its result registered out of
// ST_FIN; set and read finish in ST_READ. busy is high until then, so a new request is taken
// only after the last is done; a draw uses the shared multiply/fold unit twice, and the seed
// memory has separate read and write ports. reset: rst_n is asynchronous; afterwards busy
// stays high while the seed memory is loaded with the start seed table, zero beyond it, one entry per cycle
// the receiver cannot stall: done marks each result for exactly one cycle
module multi_stream_lehmer_rng #(
    parameter int NUM_STREAMS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  logic [6:0]  stream,
    input  logic [30:0] seed_in,
    output logic        busy,
    output logic        done,
    output logic [24:0] fraction_numerator,
    output logic [30:0] seed_out
);
    import lrng_pkg::*;

    localparam int AW = $clog2(NUM_STREAMS);

    // one-hot sequencer
    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_READ = 6'b000100,
        ST_REDA = 6'b001000,
        ST_MULB = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     init_cnt_reg;
    logic [AW-1:0]     init_cnt_next;
    logic              done_reg;
    logic              done_next;

    // request payload held for the duration of the operation
    logic [1:0]        op_reg;
    logic [AW-1:0]     addr_reg;
    logic              inr_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [SEED_W-1:0] z_reg;
    logic [SEED_W-1:0] z_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic [SEED_W-1:0] sout_reg;
    logic [SEED_W-1:0] sout_next;

    // seed memory, registered read taken when a request is accepted
    logic [SEED_W-1:0] seed_mem [0:NUM_STREAMS-1];
    logic [SEED_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SEED_W-1:0] mem_wdata;

    logic              accept;
    logic [31:0]       stream_ext;
    logic              in_range;
    logic [SEED_W-1:0] seed_sat;
    logic [31:0]       init_ext;
    logic [SEED_W-1:0] init_val;

    logic              mul_load;
    logic              mul_use_b;
    logic [SEED_W-1:0] mul_operand;
    logic [SEED_W-1:0] mul_reduced;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // stream index widened so any depth compares and slices the same way
    assign stream_ext = 32'(stream);
    assign in_range   = (stream_ext < 32'(NUM_STREAMS));
    // the all-ones value is not a valid seed, clamp it
    assign seed_sat   = (seed_in == PM_MODULUS) ? PM_SEED_MAX : seed_in;

    // start value for the loading sweep: table entries first, zero beyond
    assign init_ext = 32'(init_cnt_reg);
    assign init_val = (init_ext < 32'(SEED_TABLE_LEN)) ? SEED_TABLE[init_ext[6:0]] : '0;

    lrng_mulmod u_mulmod (
        .clk     (clk),
        .load    (mul_load),
        .use_b   (mul_use_b),
        .operand (mul_operand),
        .reduced (mul_reduced)
    );

    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        done_next     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = seed_reg;
        mul_load      = 1'b0;
        mul_use_b     = 1'b0;
        mul_operand   = rd_data_reg;
        z_next        = z_reg;
        frac_next     = frac_reg;
        sout_next     = sout_reg;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = init_val;
                if (init_cnt_reg == AW'(NUM_STREAMS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (inr_reg && (op_reg == OP_DRAW))
                begin
                    // first step: seed times 24112
                    mul_load   = 1'b1;
                    state_next = ST_REDA;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    frac_next  = '0;
                    if (!inr_reg)
                    begin
                        sout_next = '0;
                    end
                    else if (op_reg == OP_SET)
                    begin
                        mem_we    = 1'b1;
                        sout_next = seed_reg;
                    end
                    else
                    begin
                        // read, and the spare opcode behaves the same
                        sout_next = rd_data_reg;
                    end
                end
            end
            ST_REDA:
            begin
                z_next     = mul_reduced;
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                // second step: times 26143
                mul_load    = 1'b1;
                mul_use_b   = 1'b1;
                mul_operand = z_reg;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mul_reduced;
                done_next  = 1'b1;
                frac_next  = FRAC_W'({1'b0, mul_reduced[SEED_W-1:7] | 24'd1}) + 25'd1;
                sout_next  = mul_reduced;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            addr_reg <= stream_ext[AW-1:0];
            inr_reg  <= in_range;
            seed_reg <= seed_sat;
        end
        z_reg    <= z_next;
        frac_reg <= frac_next;
        sout_reg <= sout_next;
    end

    // memory: the sequencer lets at most one request touch it at a time,
    // so a write always lands before the next request's read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seed_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= seed_mem[stream_ext[AW-1:0]];
        end
    end

    assign done               = done_reg;
    assign fraction_numerator = frac_reg;
    assign seed_out           = sout_reg;

endmodule

// ===== rtl/lrng_checker.sv =====
module lrng_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [24:0] fraction_numerator,
    input logic [30:0] seed_out
);

    // a taken request keeps the block occupied in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy low next cycle");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // results are single-cycle pulses, never back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // the numerator is always even: zero for set and read, (x | 1) + 1 for a draw
    a_frac_even: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !fraction_numerator[0])
        else $error("odd fraction numerator");

    // stored seeds stay below the modulus
    a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (seed_out != 31'h7FFF_FFFF))
        else $error("seed equal to the modulus");

endmodule

bind multi_stream_lehmer_rng lrng_checker u_lrng_checker (.*);

// ===== tb/multi_stream_lehmer_rng_tb.sv =====
`timescale 1ns / 100ps

module multi_stream_lehmer_rng_tb;
    import lrng_pkg::*;

    localparam int NUM_STREAMS     = 128;
    localparam int RANDOM_REQUESTS = 1030;
    localparam int DRAIN_LIMIT     = 2000;

    // one predicted response, tagged with the stream for messages
    typedef struct packed {
        logic [6:0]        stream;
        logic [FRAC_W-1:0] fraction;
        logic [SEED_W-1:0] seed;
    } rng_response_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic [1:0]        op;
    logic [6:0]        stream;
    logic [SEED_W-1:0] seed_in;
    logic              busy;
    logic              done;
    logic [FRAC_W-1:0] fraction_numerator;
    logic [SEED_W-1:0] seed_out;

    // predicted responses, oldest first
    rng_response_t     expected_responses[$];
    // private copy of the seed bank, kept in step with accepted requests
    logic [SEED_W-1:0] model_seeds [0:NUM_STREAMS-1];
    int                error_count;
    // set during the long stretch with no idle gaps on the request side
    bit                no_idle;

    multi_stream_lehmer_rng #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .op                 (op),
        .stream             (stream),
        .seed_in            (seed_in),
        .busy               (busy),
        .done               (done),
        .fraction_numerator (fraction_numerator),
        .seed_out           (seed_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // exact product modulo 2^31-1 using a wide intermediate
    function automatic logic [SEED_W-1:0] mulmod_mersenne(input logic [SEED_W-1:0] z,
                                                          input logic [MULT_W-1:0] m);
        longint unsigned prod;
        prod = z;
        prod = prod * m;
        return SEED_W'(prod % PM_MODULUS);
    endfunction

    // applies one request to the private seed bank and returns the response it should give
    function automatic rng_response_t predict_response(input logic [1:0]        req_op,
                                                       input logic [6:0]        idx,
                                                       input logic [SEED_W-1:0] new_seed);
        rng_response_t     r;
        logic [SEED_W-1:0] z;
        r = '0;
        r.stream = idx;
        // out-of-range stream: nothing changes, all-zero response
        if (int'(idx) >= NUM_STREAMS)
            return r;
        case (req_op)
            OP_DRAW:
            begin
                // two chained multiplies; a zero seed stays at zero
                z = mulmod_mersenne(mulmod_mersenne(model_seeds[idx], PM_MUL_A), PM_MUL_B);
                model_seeds[idx] = z;
                r.fraction = {1'b0, z[SEED_W-1:7] | 24'd1} + 25'd1;
            end
            OP_SET:
                // the modulus itself is clamped to the largest legal seed
                model_seeds[idx] = (new_seed > PM_SEED_MAX) ? PM_SEED_MAX : new_seed;
            default:
                ; // read, and the spare code which behaves as a read
        endcase
        r.seed = model_seeds[idx];
        return r;
    endfunction

    // response checking first, then prediction for a request taken at this edge,
    // so a request can never be matched against its own response in the same step
    always @(posedge clk)
    begin : response_monitor
        rng_response_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_responses.size() == 0)
                begin
                    error_count++;
                    $display("%0t: response with none expected: fraction_numerator %0d seed_out %0d",
                             $time, fraction_numerator, seed_out);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (fraction_numerator !== want.fraction)
                    begin
                        error_count++;
                        $display("%0t: stream %0d fraction_numerator expected %0d got %0d",
                                 $time, want.stream, want.fraction, fraction_numerator);
                    end
                    if (seed_out !== want.seed)
                    begin
                        error_count++;
                        $display("%0t: stream %0d seed_out expected %0d got %0d",
                                 $time, want.stream, want.seed, seed_out);
                    end
                end
            end
            if (start && !busy)
                expected_responses.push_back(predict_response(op, stream, seed_in));
        end
    end

    // sends one request: optional idle gap, then hold start until busy is low at a rising edge
    task automatic send_request(input logic [1:0]        req_op,
                                input logic [6:0]        idx,
                                input logic [SEED_W-1:0] value);
        int   gap;
        logic busy_seen;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 35)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            // idle cycles carry junk on the payload lines
            @(negedge clk);
            start   = 1'b0;
            op      = 2'($urandom);
            stream  = 7'($urandom);
            seed_in = SEED_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   = 1'b1;
        op      = req_op;
        stream  = idx;
        seed_in = value;
        // busy only moves on a rising edge, so its value here holds until the next one
        busy_seen = busy;
        while (busy_seen)
        begin
            @(negedge clk);
            busy_seen = busy;
        end
        @(posedge clk);
    endtask

    // start seeds, reads of the table edges and the zero fixed point
    task automatic test_reset_state();
        send_request(OP_READ, 7'd0, '0);
        send_request(OP_READ, 7'd1, '0);
        send_request(OP_READ, 7'd100, SEED_W'($urandom));
        send_request(OP_READ, 7'd101, '0);
        send_request(2'd3, 7'd127, '1);
        send_request(OP_DRAW, 7'd0, '0);
        send_request(OP_DRAW, 7'd0, '1);
        send_request(OP_DRAW, 7'd1, '0);
        send_request(OP_DRAW, 7'd100, '0);
        send_request(OP_DRAW, 7'd101, '0);
    endtask

    // seed writes at the extremes, saturation and back-to-back draws on one stream
    task automatic test_seed_limits();
        send_request(OP_SET, 7'd5, PM_MODULUS);
        send_request(OP_READ, 7'd5, '0);
        send_request(OP_DRAW, 7'd5, '0);
        send_request(OP_SET, 7'd6, '0);
        send_request(OP_DRAW, 7'd6, '0);
        send_request(OP_SET, 7'd7, 31'd1);
        send_request(OP_DRAW, 7'd7, '0);
        send_request(OP_SET, 7'd127, PM_SEED_MAX);
        send_request(OP_DRAW, 7'd127, '1);
        send_request(OP_SET, 7'd9, 31'h5555_5555);
        send_request(OP_DRAW, 7'd9, '0);
        send_request(OP_DRAW, 7'd9, '0);
        send_request(2'd3, 7'd9, 31'h2AAA_AAAA);
    endtask

    // random traffic, mostly draws, biased towards a few hot streams so that
    // repeats on one stream follow each other closely
    task automatic test_random_traffic();
        int          pick;
        logic [1:0]  req_op;
        logic [6:0]  idx;
        logic [SEED_W-1:0] value;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            no_idle = (i >= 300 && i < 560);
            pick = $urandom_range(99);
            if (pick < 55)
                req_op = OP_DRAW;
            else if (pick < 72)
                req_op = OP_SET;
            else if (pick < 92)
                req_op = OP_READ;
            else
                req_op = 2'd3;
            if ($urandom_range(99) < 45)
                idx = $urandom_range(1) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(124, 127));
            else
                idx = 7'($urandom);
            pick = $urandom_range(99);
            if (pick < 8)
                value = PM_MODULUS;
            else if (pick < 12)
                value = '0;
            else if (pick < 16)
                value = PM_SEED_MAX;
            else
                value = SEED_W'($urandom);
            send_request(req_op, idx, value);
        end
        no_idle = 1'b0;
    endtask

    // drop start, wait for every outstanding response, then idle before returning
    task automatic drain_responses();
        int waited;
        @(negedge clk);
        start  = 1'b0;
        waited = 0;
        while (expected_responses.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_responses.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d responses never arrived", $time, expected_responses.size());
        end
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        start       = 1'b0;
        op          = OP_DRAW;
        stream      = '0;
        seed_in     = '0;
        rst_n       = 1'b0;
        error_count = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < NUM_STREAMS; i++)
            model_seeds[i] = (i < SEED_TABLE_LEN) ? SEED_TABLE[i] : '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // the block stays busy while it loads its seed table; send_request waits it out
        test_reset_state();
        test_seed_limits();
        test_random_traffic();
        drain_responses();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
